// ----- rtl/core/abir_pkg.sv -----
// Package for the affine bilinear image resampler.
// Holds register index codes and Q16.16 constants; no dependencies.
package abir_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_COEF_XX    = 3'd0;
    localparam logic [2:0] REG_COEF_XY    = 3'd1;
    localparam logic [2:0] REG_COEF_YX    = 3'd2;
    localparam logic [2:0] REG_COEF_YY    = 3'd3;
    localparam logic [2:0] REG_OFFSET_X   = 3'd4;
    localparam logic [2:0] REG_OFFSET_Y   = 3'd5;
    localparam logic [2:0] REG_SRC_WIDTH  = 3'd6;
    localparam logic [2:0] REG_SRC_HEIGHT = 3'd7;

    // input item function codes
    localparam logic FUNC_WRITE   = 1'b0;
    localparam logic FUNC_REQUEST = 1'b1;

    // Q16.16 constants
    localparam logic [16:0] ONE_Q16  = 17'h10000;
    localparam logic [41:0] HALF_Q16 = 42'h8000;

    // wide position and clamp widths
    localparam int POS_W   = 42;
    localparam int LIM_W   = 13;

    typedef logic [31:0] t_pixel;

endpackage

// ----- rtl/core/affine_bilinear_image_resampler.sv -----
// Affine bilinear image resampler, seven register stages, one item per cycle when not stalled.
// Each result leaves the stage 7 register; throughput 1 item per cycle while the output is not stalled.
// Four neighbor reads per request come from two copies of the frame store,
// each read at two addresses in one cycle. Writes cause no result.
// Reset (synchronous, active low) clears the pipeline valid bits and loads the
// register defaults; the frame store is not cleared.
module affine_bilinear_image_resampler
    import abir_pkg::*;
#(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_func,
    input  logic [6:0]  i_col,
    input  logic [6:0]  i_row,
    input  logic [7:0]  i_in_red,
    input  logic [7:0]  i_in_green,
    input  logic [7:0]  i_in_blue,
    input  logic [7:0]  i_in_alpha,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_red,
    output logic [7:0]  o_out_green,
    output logic [7:0]  o_out_blue,
    output logic [7:0]  o_out_alpha
);

    localparam int IW    = (MAX_WIDTH  > 2) ? $clog2(MAX_WIDTH)  : 1;
    localparam int IH    = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    // clamp a signed index into 0..hi
    function automatic logic [LIM_W-1:0] clamp_idx(input logic signed [26:0] v,
                                                   input logic [LIM_W-1:0] hi);
        logic signed [26:0] hs;
        hs = $signed({{(27-LIM_W){1'b0}}, hi});
        if (v < 0)
            return '0;
        else if (v > hs)
            return hi;
        else
            return v[LIM_W-1:0];
    endfunction

    // clamp an 8-bit size to 1..maxv
    function automatic logic [LIM_W-1:0] eff_dim(input logic [7:0] v,
                                                 input logic [LIM_W-1:0] maxv);
        if (v == 8'd0)
            return LIM_W'(1);
        else if ({{(LIM_W-8){1'b0}}, v} > maxv)
            return maxv;
        else
            return {{(LIM_W-8){1'b0}}, v};
    endfunction

    // configuration registers
    logic signed [31:0] r_coef_xx, r_coef_xy, r_coef_yx, r_coef_yy;
    logic signed [31:0] r_offset_x, r_offset_y;
    logic [7:0]         r_src_width, r_src_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_xx    <= 32'sh10000;
            r_coef_xy    <= '0;
            r_coef_yx    <= '0;
            r_coef_yy    <= 32'sh10000;
            r_offset_x   <= '0;
            r_offset_y   <= '0;
            r_src_width  <= 8'd128;
            r_src_height <= 8'd128;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_COEF_XX:    r_coef_xx    <= i_cfg_data;
                REG_COEF_XY:    r_coef_xy    <= i_cfg_data;
                REG_COEF_YX:    r_coef_yx    <= i_cfg_data;
                REG_COEF_YY:    r_coef_yy    <= i_cfg_data;
                REG_OFFSET_X:   r_offset_x   <= i_cfg_data;
                REG_OFFSET_Y:   r_offset_y   <= i_cfg_data;
                REG_SRC_WIDTH:  r_src_width  <= i_cfg_data[7:0];
                REG_SRC_HEIGHT: r_src_height <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // clamp limits from the size registers
    logic [LIM_W-1:0] w_lim, h_lim;
    assign w_lim = eff_dim(r_src_width,  LIM_W'(MAX_WIDTH))  - LIM_W'(1);
    assign h_lim = eff_dim(r_src_height, LIM_W'(MAX_HEIGHT)) - LIM_W'(1);

    // stage valid bits and per-stage enables; a stage loads when empty or moving
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7;
    logic en1, en2, en3, en4, en5, en6, en7;
    logic r_func4;
    assign en7 = !r_v7 || !i_out_stall;
    assign en6 = !r_v6 || en7;
    assign en5 = !r_v5 || en6;
    assign en4 = !r_v4 || en5;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign o_in_stall = !en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            {r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7} <= '0;
        end else begin
            if (en1) r_v1 <= i_in_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4 && (r_func4 == FUNC_REQUEST);
            if (en6) r_v6 <= r_v5;
            if (en7) r_v7 <= r_v6;
        end
    end

    // stage 1: capture item, coefficient products
    logic               r_func1;
    logic [6:0]         r_col1, r_row1;
    t_pixel             r_pix1;
    logic signed [39:0] r_pxc, r_pxr, r_pyc, r_pyr;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_func1 <= i_func;
            r_col1  <= i_col;
            r_row1  <= i_row;
            r_pix1  <= {i_in_alpha, i_in_blue, i_in_green, i_in_red};
            r_pxc   <= 40'(r_coef_xx) * 40'($signed({1'b0, i_col}));
            r_pxr   <= 40'(r_coef_xy) * 40'($signed({1'b0, i_row}));
            r_pyc   <= 40'(r_coef_yx) * 40'($signed({1'b0, i_col}));
            r_pyr   <= 40'(r_coef_yy) * 40'($signed({1'b0, i_row}));
        end
    end

    // stage 2: source position less one half texel
    logic                    r_func2;
    logic [6:0]              r_col2, r_row2;
    t_pixel                  r_pix2;
    logic signed [POS_W-1:0] r_gx, r_gy;

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_func2 <= r_func1;
            r_col2  <= r_col1;
            r_row2  <= r_row1;
            r_pix2  <= r_pix1;
            r_gx    <= POS_W'(r_offset_x) + POS_W'(r_pxc) + POS_W'(r_pxr)
                       - $signed(HALF_Q16);
            r_gy    <= POS_W'(r_offset_y) + POS_W'(r_pyc) + POS_W'(r_pyr)
                       - $signed(HALF_Q16);
        end
    end

    // stage 3: floor, fraction, clamped neighbor indices
    logic               r_func3;
    logic [6:0]         r_col3, r_row3;
    t_pixel             r_pix3;
    logic [15:0]        r_fx3, r_fy3;
    logic [LIM_W-1:0]   r_xa, r_xb, r_ya, r_yb;
    logic signed [26:0] x0, y0;
    assign x0 = 27'($signed(r_gx[POS_W-1:16]));
    assign y0 = 27'($signed(r_gy[POS_W-1:16]));

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_func3 <= r_func2;
            r_col3  <= r_col2;
            r_row3  <= r_row2;
            r_pix3  <= r_pix2;
            r_fx3   <= r_gx[15:0];
            r_fy3   <= r_gy[15:0];
            r_xa    <= clamp_idx(x0, w_lim);
            r_xb    <= clamp_idx(x0 + 27'sd1, w_lim);
            r_ya    <= clamp_idx(y0, h_lim);
            r_yb    <= clamp_idx(y0 + 27'sd1, h_lim);
        end
    end

    // stage 4: store addresses; a write uses the first address
    logic          r_wr_ok4;
    t_pixel        r_pix4;
    logic [15:0]   r_fx4, r_fy4;
    logic [AW-1:0] r_a00, r_a10, r_a01, r_a11;

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_func4  <= r_func3;
            r_pix4   <= r_pix3;
            r_fx4    <= r_fx3;
            r_fy4    <= r_fy3;
            r_wr_ok4 <= ({{(LIM_W-7){1'b0}}, r_col3} < LIM_W'(MAX_WIDTH))
                     && ({{(LIM_W-7){1'b0}}, r_row3} < LIM_W'(MAX_HEIGHT));
            if (r_func3 == FUNC_WRITE) begin
                r_a00 <= AW'(AW'(r_row3) * AW'(MAX_WIDTH) + AW'(r_col3));
            end else begin
                r_a00 <= AW'(AW'(r_ya[IH-1:0]) * AW'(MAX_WIDTH) + AW'(r_xa[IW-1:0]));
            end
            r_a10 <= AW'(AW'(r_ya[IH-1:0]) * AW'(MAX_WIDTH) + AW'(r_xb[IW-1:0]));
            r_a01 <= AW'(AW'(r_yb[IH-1:0]) * AW'(MAX_WIDTH) + AW'(r_xa[IW-1:0]));
            r_a11 <= AW'(AW'(r_yb[IH-1:0]) * AW'(MAX_WIDTH) + AW'(r_xb[IW-1:0]));
        end
    end

    // stage 5: frame store, two copies for four reads per cycle
    t_pixel      mem_top [DEPTH];
    t_pixel      mem_bot [DEPTH];
    t_pixel      r_p00, r_p10, r_p01, r_p11;
    logic [15:0] r_fx5, r_fy5;

    always_ff @(posedge i_clk) begin
        if (en5 && r_v4 && (r_func4 == FUNC_WRITE) && r_wr_ok4) begin
            mem_top[r_a00] <= r_pix4;
            mem_bot[r_a00] <= r_pix4;
        end
        if (en5) begin
            r_p00 <= mem_top[r_a00];
            r_p10 <= mem_top[r_a10];
            r_p01 <= mem_bot[r_a01];
            r_p11 <= mem_bot[r_a11];
            r_fx5 <= r_fx4;
            r_fy5 <= r_fy4;
        end
    end

    // stage 6: horizontal blend per channel
    logic [23:0] r_top [4];
    logic [23:0] r_bot [4];
    logic [15:0] r_fy6;
    logic [16:0] wx0, wx1;
    assign wx1 = {1'b0, r_fx5};
    assign wx0 = ONE_Q16 - wx1;

    always_ff @(posedge i_clk) begin
        if (en6) begin
            r_fy6 <= r_fy5;
            for (int c = 0; c < 4; c++) begin
                r_top[c] <= 24'(r_p00[8*c +: 8]) * 24'(wx0)
                          + 24'(r_p10[8*c +: 8]) * 24'(wx1);
                r_bot[c] <= 24'(r_p01[8*c +: 8]) * 24'(wx0)
                          + 24'(r_p11[8*c +: 8]) * 24'(wx1);
            end
        end
    end

    // stage 7: vertical blend, round half up, output register
    logic [7:0]  r_out [4];
    logic [16:0] wy0, wy1;
    logic [40:0] vsum [4];
    assign wy1 = {1'b0, r_fy6};
    assign wy0 = ONE_Q16 - wy1;

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            vsum[c] = 41'(r_top[c]) * 41'(wy0) + 41'(r_bot[c]) * 41'(wy1)
                    + 41'h0_8000_0000;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en7) begin
            for (int c = 0; c < 4; c++) begin
                r_out[c] <= vsum[c][39:32];
            end
        end
    end

    assign o_out_valid = r_v7;
    assign o_out_red   = r_out[0];
    assign o_out_green = r_out[1];
    assign o_out_blue  = r_out[2];
    assign o_out_alpha = r_out[3];

    // an empty entry stage never holds off the input
    a_no_stall_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v1 |-> !o_in_stall)
        else $error("input stalled with empty entry stage");

    // a stalled result stays in the output register
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v7 && i_out_stall |=> r_v7 && $stable(r_out[0]) && $stable(r_out[3]))
        else $error("stalled result lost");

    // full pipeline with stalled output must stall the input
    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && r_v2 && r_v3 && r_v4 && r_v5 && r_v6 && r_v7 && i_out_stall
        |-> o_in_stall)
        else $error("input taken into a full pipeline");

endmodule
